// File: hw/rtl/kf1d_pkg.sv
// Package for the scalar Kalman filter unit: opcodes, reset values and datapath widths.
// Used by the channel interfaces, the multiplier, the divider and the top level.
// Has no dependencies of its own.
package kf1d_pkg;

    localparam int DATA_W = 32;
    localparam int DT_W   = 16;

    typedef logic [1:0] t_opcode;

    localparam t_opcode OP_PREDICT = 2'd0;
    localparam t_opcode OP_UPDATE  = 2'd1;
    localparam t_opcode OP_RESET   = 2'd2;

    localparam logic [DATA_W-1:0] NOISE_RST  = 32'd6554;
    localparam logic [DATA_W-1:0] SPREAD_RST = 32'd65536;

    // Shared multiplier: signed operands, A wide enough for a 33-bit magnitude, B for a 32-bit one.
    localparam int MUL_A_W = 34;
    localparam int MUL_B_W = 33;
    localparam int MUL_P_W = MUL_A_W + MUL_B_W;

    // Divider: 65-bit dividend, 33-bit divisor, quotient known to fit 33 bits.
    localparam int DIV_NUM_W = 65;
    localparam int DIV_DEN_W = 33;
    localparam int DIV_STEPS = 33;
    localparam int DIV_CNT_W = 6;

endpackage

// File: hw/rtl/kf1d_if.sv
// Valid/ready channel interfaces for the scalar Kalman filter unit.
// Payload types come from kf1d_pkg.
interface kf1d_in_if;
    logic                             valid;
    logic                             ready;
    kf1d_pkg::t_opcode                opcode;
    logic signed [kf1d_pkg::DATA_W-1:0] velocity;
    logic [kf1d_pkg::DT_W-1:0]        step_time;
    logic signed [kf1d_pkg::DATA_W-1:0] value_in;
    logic [kf1d_pkg::DATA_W-1:0]      spread_in;

    modport source (output valid, opcode, velocity, step_time, value_in, spread_in,
                    input ready);
    modport sink (input valid, opcode, velocity, step_time, value_in, spread_in,
                  output ready);
endinterface

interface kf1d_out_if;
    logic                             valid;
    logic                             ready;
    logic signed [kf1d_pkg::DATA_W-1:0] mean_out;
    logic [kf1d_pkg::DATA_W-1:0]      spread_out;
    logic                             bad_input;
    logic                             saturated;

    modport source (output valid, mean_out, spread_out, bad_input, saturated,
                    input ready);
    modport sink (input valid, mean_out, spread_out, bad_input, saturated,
                  output ready);
endinterface

// File: hw/rtl/kalman_1d_predict_update_unit.sv
// Top level of the scalar Kalman filter unit: sequencer, state and output register.
// Depends on kf1d_pkg, kf1d_if.sv, kf1d_mul and kf1d_div.
//
//   Channel   Dir   Handshake            Payload
//   i_in      in    valid/ready          opcode, velocity, step_time, value_in, spread_in
//   o_out     out   valid/ready          mean_out, spread_out, bad_input, saturated
//   i_cfg     in    write enable only    noise_rate (i_cfg_wdata)
//
// Predict runs through S_PMUL1, S_PMUL2, S_PMUL3 and S_PDONE to S_FIN; reset, an unused
// opcode or a zero variance go straight to S_FIN. Update runs its two
// 33-step divisions through the one shared divider.
// Input is taken only while the sequencer is idle, so the next transaction can be accepted
// in the cycle after the result is loaded; a finished result may still wait in the output
// register. Synchronous active-low reset returns control to idle and loads the reset state.
module kalman_1d_predict_update_unit (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_cfg_we,
    input  logic [kf1d_pkg::DATA_W-1:0]   i_cfg_wdata,
    kf1d_in_if.sink                       i_in,
    kf1d_out_if.source                    o_out
);

    typedef enum logic [3:0] {
        S_IDLE,
        S_PMUL1,
        S_PMUL2,
        S_PMUL3,
        S_PDONE,
        S_UMUL1,
        S_UDIV1,
        S_UWAIT1,
        S_UDIV2,
        S_UWAIT2,
        S_FIN
    } t_state;

    localparam int W = kf1d_pkg::DATA_W;

    t_state                     r_state;
    logic [W-1:0]               r_noise;
    logic signed [W-1:0]        r_mean;
    logic [W-1:0]               r_spread;
    logic signed [W-1:0]        r_vel;
    logic [kf1d_pkg::DT_W-1:0]  r_dt;
    logic [W-1:0]               r_vz;
    logic [W:0]                 r_mag;
    logic                       r_neg;
    logic [W:0]                 r_sum;
    logic                       r_bad;
    logic                       r_sat;
    logic                       r_out_valid;
    logic signed [W-1:0]        r_out_mean;
    logic [W-1:0]               r_out_spread;
    logic                       r_out_bad;
    logic                       r_out_sat;

    logic in_fire;
    logic out_free;

    logic signed [kf1d_pkg::MUL_A_W-1:0] mul_a;
    logic signed [kf1d_pkg::MUL_B_W-1:0] mul_b;
    logic                                mul_en;
    logic signed [kf1d_pkg::MUL_P_W-1:0] mul_p;

    logic                                div_start;
    logic [kf1d_pkg::DIV_NUM_W-1:0]      div_num;
    logic                                div_done;
    logic [kf1d_pkg::DIV_STEPS-1:0]      div_quo;

    logic signed [W:0]   n_diff;
    logic [W:0]          n_mag;
    logic [W:0]          n_sum;
    logic signed [47:0]  n_rnd;
    logic signed [W:0]   n_pmean;
    logic [W:0]          n_add;
    logic [W+1:0]        n_pspread;
    logic signed [W+1:0] n_umean;

    assign in_fire     = i_in.valid && i_in.ready;
    assign i_in.ready  = (r_state == S_IDLE);
    assign out_free    = !r_out_valid || o_out.ready;

    always_comb begin
        n_diff = {i_in.value_in[W-1], i_in.value_in} - {r_mean[W-1], r_mean};
        n_mag  = n_diff[W] ? (W+1)'(-n_diff) : n_diff;
        n_sum  = {1'b0, r_spread} + {1'b0, i_in.spread_in};
    end

    // Shared multiplier operand selection per sequencer step.
    always_comb begin
        mul_a  = '0;
        mul_b  = '0;
        mul_en = 1'b0;
        case (r_state)
            S_PMUL1: begin
                mul_a  = kf1d_pkg::MUL_A_W'(r_vel);
                mul_b  = {17'b0, r_dt};
                mul_en = 1'b1;
            end
            S_PMUL2: begin
                mul_a  = {18'b0, r_dt};
                mul_b  = {17'b0, r_dt};
                mul_en = 1'b1;
            end
            S_PMUL3: begin
                mul_a  = {2'b0, r_noise};
                mul_b  = {1'b0, mul_p[W-1:0]};
                mul_en = 1'b1;
            end
            S_UMUL1: begin
                mul_a  = {1'b0, r_mag};
                mul_b  = {1'b0, r_spread};
                mul_en = 1'b1;
            end
            S_UDIV1: begin
                mul_a  = {2'b0, r_spread};
                mul_b  = {1'b0, r_vz};
                mul_en = 1'b1;
            end
            default: begin
                mul_en = 1'b0;
            end
        endcase
    end

    // Both divisions round half up by adding half the summed variance.
    assign div_start = (r_state == S_UDIV1) || (r_state == S_UDIV2);
    assign div_num   = mul_p[kf1d_pkg::DIV_NUM_W-1:0] + {32'b0, r_sum[W:1]};

    always_comb begin
        n_rnd     = mul_p[47:0] + 48'sd32768;
        n_pmean   = {r_mean[W-1], r_mean} + {n_rnd[47], n_rnd[47:16]};
        n_add     = {1'b0, mul_p[63:32]} + (W+1)'(mul_p[31]);
        n_pspread = {2'b0, r_spread} + {1'b0, n_add};
        n_umean   = r_neg ? ({{2{r_mean[W-1]}}, r_mean} - {1'b0, div_quo})
                          : ({{2{r_mean[W-1]}}, r_mean} + {1'b0, div_quo});
    end

    kf1d_mul u_mul (
        .i_clk (i_clk),
        .i_en  (mul_en),
        .i_a   (mul_a),
        .i_b   (mul_b),
        .o_p   (mul_p)
    );

    kf1d_div u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (div_start),
        .i_num   (div_num),
        .i_den   (r_sum),
        .o_done  (div_done),
        .o_quo   (div_quo)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_noise     <= kf1d_pkg::NOISE_RST;
            r_mean      <= '0;
            r_spread    <= kf1d_pkg::SPREAD_RST;
            r_bad       <= 1'b0;
            r_sat       <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (i_cfg_we) begin
                r_noise <= i_cfg_wdata;
            end
            if (r_state == S_FIN && out_free) begin
                r_out_valid <= 1'b1;
            end else if (o_out.ready) begin
                r_out_valid <= 1'b0;
            end
            case (r_state)
                S_IDLE: begin
                    if (in_fire) begin
                        r_sat <= 1'b0;
                        r_vel <= i_in.velocity;
                        r_dt  <= i_in.step_time;
                        r_vz  <= i_in.spread_in;
                        r_mag <= n_mag;
                        r_neg <= n_diff[W];
                        r_sum <= n_sum;
                        case (i_in.opcode)
                            kf1d_pkg::OP_PREDICT: begin
                                r_bad   <= 1'b0;
                                r_state <= S_PMUL1;
                            end
                            kf1d_pkg::OP_UPDATE: begin
                                if (i_in.spread_in == '0) begin
                                    r_bad   <= 1'b1;
                                    r_state <= S_FIN;
                                end else begin
                                    r_bad   <= 1'b0;
                                    r_state <= S_UMUL1;
                                end
                            end
                            kf1d_pkg::OP_RESET: begin
                                if (i_in.spread_in == '0) begin
                                    r_bad <= 1'b1;
                                end else begin
                                    r_bad    <= 1'b0;
                                    r_mean   <= i_in.value_in;
                                    r_spread <= i_in.spread_in;
                                end
                                r_state <= S_FIN;
                            end
                            default: begin
                                r_bad   <= 1'b0;
                                r_state <= S_FIN;
                            end
                        endcase
                    end
                end
                S_PMUL1: begin
                    r_state <= S_PMUL2;
                end
                S_PMUL2: begin
                    // Clamp when the 33-bit sum leaves the signed 32-bit range.
                    if (n_pmean[W] != n_pmean[W-1]) begin
                        r_mean <= n_pmean[W] ? {1'b1, {(W-1){1'b0}}} : {1'b0, {(W-1){1'b1}}};
                        r_sat  <= 1'b1;
                    end else begin
                        r_mean <= n_pmean[W-1:0];
                    end
                    r_state <= S_PMUL3;
                end
                S_PMUL3: begin
                    r_state <= S_PDONE;
                end
                S_PDONE: begin
                    if (n_pspread[W+1:W] != 2'b00) begin
                        r_spread <= '1;
                        r_sat    <= 1'b1;
                    end else begin
                        r_spread <= n_pspread[W-1:0];
                    end
                    r_state <= S_FIN;
                end
                S_UMUL1: begin
                    r_state <= S_UDIV1;
                end
                S_UDIV1: begin
                    r_state <= S_UWAIT1;
                end
                S_UWAIT1: begin
                    if (div_done) begin
                        r_mean  <= n_umean[W-1:0];
                        r_state <= S_UDIV2;
                    end
                end
                S_UDIV2: begin
                    r_state <= S_UWAIT2;
                end
                S_UWAIT2: begin
                    if (div_done) begin
                        r_spread <= div_quo[W-1:0];
                        r_state  <= S_FIN;
                    end
                end
                S_FIN: begin
                    if (out_free) begin
                        r_out_mean   <= r_mean;
                        r_out_spread <= r_spread;
                        r_out_bad    <= r_bad;
                        r_out_sat    <= r_sat;
                        r_state      <= S_IDLE;
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

    assign o_out.valid      = r_out_valid;
    assign o_out.mean_out   = r_out_mean;
    assign o_out.spread_out = r_out_spread;
    assign o_out.bad_input  = r_out_bad;
    assign o_out.saturated  = r_out_sat;

    a_div_done_in_wait: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        div_done |-> (r_state == S_UWAIT1 || r_state == S_UWAIT2))
        else $error("divider finished outside a wait step");

    a_out_from_fin: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(r_out_valid) |-> $past(r_state == S_FIN))
        else $error("result transaction raised outside the finish step");

    a_flags_exclusive: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out.valid |-> !(o_out.bad_input && o_out.saturated))
        else $error("bad input and saturation flagged together");

endmodule

// File: hw/rtl/kf1d_mul.sv
// Shared signed multiplier with a registered product and a load enable.
// Widths come from kf1d_pkg.
module kf1d_mul (
    input  logic                                i_clk,
    input  logic                                i_en,
    input  logic signed [kf1d_pkg::MUL_A_W-1:0] i_a,
    input  logic signed [kf1d_pkg::MUL_B_W-1:0] i_b,
    output logic signed [kf1d_pkg::MUL_P_W-1:0] o_p
);

    logic signed [kf1d_pkg::MUL_P_W-1:0] r_p;

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_p <= i_a * i_b;
        end
    end

    assign o_p = r_p;

endmodule

// File: hw/rtl/kf1d_div.sv
// Restoring divider, one quotient bit per cycle, for the Gaussian product update.
// Widths and step count come from kf1d_pkg; the caller guarantees the quotient fits.
module kf1d_div (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_start,
    input  logic [kf1d_pkg::DIV_NUM_W-1:0]      i_num,
    input  logic [kf1d_pkg::DIV_DEN_W-1:0]      i_den,
    output logic                                o_done,
    output logic [kf1d_pkg::DIV_STEPS-1:0]      o_quo
);

    localparam int LOW_W = kf1d_pkg::DIV_STEPS;
    localparam int REM_W = kf1d_pkg::DIV_DEN_W;

    logic                              r_busy;
    logic                              r_done;
    logic [kf1d_pkg::DIV_CNT_W-1:0]    r_cnt;
    logic [REM_W-1:0]                  r_rem;
    logic [LOW_W-1:0]                  r_low;
    logic [kf1d_pkg::DIV_DEN_W-1:0]    r_den;

    logic [REM_W:0] n_trial;
    logic [REM_W:0] n_diff;
    logic           n_ge;

    always_comb begin
        n_trial = {r_rem, r_low[LOW_W-1]};
        n_diff  = n_trial - {1'b0, r_den};
        n_ge    = (n_trial >= {1'b0, r_den});
    end

    // The upper dividend bits start below the divisor, so the remainder never
    // needs more than the divisor width.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= kf1d_pkg::DIV_CNT_W'(kf1d_pkg::DIV_STEPS);
                r_rem  <= REM_W'(i_num[kf1d_pkg::DIV_NUM_W-1:LOW_W]);
                r_low  <= i_num[LOW_W-1:0];
                r_den  <= i_den;
            end else if (r_busy) begin
                r_rem <= n_ge ? n_diff[REM_W-1:0] : n_trial[REM_W-1:0];
                r_low <= {r_low[LOW_W-2:0], n_ge};
                r_cnt <= r_cnt - 1'b1;
                if (r_cnt == kf1d_pkg::DIV_CNT_W'(1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    assign o_done = r_done;
    assign o_quo  = r_low;

endmodule
